FILE: hdl/q15alu_pkg.sv
package q15alu_pkg;

    localparam int FRAC_BITS = 15;
    localparam int NUM_CELLS = FRAC_BITS;

    localparam logic signed [15:0] Q15_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q15_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_ABS = 2'd3
    } t_opcode;

    // word handed from cell to cell
    typedef struct packed {
        t_opcode     op;
        logic        sat;   // divide already settled to full scale
        logic        neg;   // quotient sign
        logic [15:0] rem;   // partial remainder
        logic [15:0] dvs;   // divisor magnitude
        logic [31:0] val;   // sum, product, or quotient bits
    } t_work;

    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = Q15_MAX;
        end else if (v < -17'sd32768) begin
            r = Q15_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/q15alu_if.sv
interface q15alu_in_if;
    import q15alu_pkg::*;

    logic               valid;
    logic               ready;
    t_opcode            opcode;
    logic signed [15:0] operand_a;
    logic signed [15:0] operand_b;

    modport source(output valid, output opcode, output operand_a, output operand_b,
                   input ready);
    modport sink(input valid, input opcode, input operand_a, input operand_b,
                 output ready);
endinterface

interface q15alu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result;

    modport source(output valid, output result, input ready);
    modport sink(input valid, input result, output ready);
endinterface

FILE: hdl/q15alu_front.sv
module q15alu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    q15alu_in_if.sink           i_in,
    input  logic                i_adv,
    output logic                o_valid,
    output q15alu_pkg::t_work   o_work
);
    import q15alu_pkg::*;

    logic               r_valid;
    t_work              r_work;
    t_work              n_work;
    logic               adv;
    logic signed [16:0] sum;
    logic signed [16:0] a_ext;
    logic signed [16:0] abs_a;
    logic [15:0]        mag_a;
    logic [15:0]        mag_b;
    logic               sgn_diff;

    assign adv        = !r_valid || i_adv;
    assign i_in.ready = adv;

    always_comb begin
        a_ext    = {i_in.operand_a[15], i_in.operand_a};
        sum      = a_ext + {i_in.operand_b[15], i_in.operand_b};
        abs_a    = i_in.operand_a[15] ? -a_ext : a_ext;
        // 16-bit negate leaves 0x8000 as 32768 unsigned
        mag_a    = i_in.operand_a[15] ? 16'(-i_in.operand_a) : i_in.operand_a;
        mag_b    = i_in.operand_b[15] ? 16'(-i_in.operand_b) : i_in.operand_b;
        sgn_diff = i_in.operand_a[15] ^ i_in.operand_b[15];

        n_work     = '0;
        n_work.op  = i_in.opcode;
        n_work.neg = sgn_diff;
        n_work.dvs = mag_b;
        n_work.rem = mag_a;
        case (i_in.opcode)
            OP_ADD: begin
                n_work.val = 32'(signed'(sat17(sum)));
            end
            OP_MUL: begin
                n_work.val = 32'(i_in.operand_a * i_in.operand_b);
            end
            OP_DIV: begin
                // also covers a zero divisor
                n_work.sat = (mag_a >= mag_b);
                n_work.val = n_work.sat ? 32'(signed'(sgn_diff ? Q15_MIN : Q15_MAX)) : '0;
            end
            OP_ABS: begin
                n_work.val = 32'(signed'(sat17(abs_a)));
            end
            default: begin
                n_work.val = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
endmodule

FILE: hdl/q15alu_cell.sv
module q15alu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  q15alu_pkg::t_work   i_work,
    input  logic                i_adv,
    output logic                o_adv,
    output logic                o_valid,
    output q15alu_pkg::t_work   o_work
);
    import q15alu_pkg::*;

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [16:0] rem2;
    logic [16:0] diff;
    logic        qbit;

    assign o_adv = !r_valid || i_adv;

    // one restoring division step
    always_comb begin
        rem2   = {i_work.rem, 1'b0};
        diff   = rem2 - {1'b0, i_work.dvs};
        qbit   = (rem2 >= {1'b0, i_work.dvs});
        n_work = i_work;
        if (i_work.op == OP_DIV && !i_work.sat) begin
            n_work.rem = qbit ? diff[15:0] : rem2[15:0];
            n_work.val = {i_work.val[30:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
endmodule

FILE: hdl/q15alu_back.sv
module q15alu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  q15alu_pkg::t_work   i_work,
    output logic                o_adv,
    q15alu_out_if.source        o_out
);
    import q15alu_pkg::*;

    logic               r_valid;
    logic signed [15:0] r_result;
    logic signed [15:0] n_result;
    logic signed [15:0] quo;

    assign o_adv = !r_valid || o_out.ready;

    always_comb begin
        quo = signed'(i_work.val[15:0]);
        case (i_work.op)
            OP_MUL: begin
                // floor shift by 15, only -1 * -1 overflows
                n_result = sat17(signed'(i_work.val[31:15]));
            end
            OP_DIV: begin
                if (i_work.sat) begin
                    n_result = quo;
                end else begin
                    n_result = i_work.neg ? -quo : quo;
                end
            end
            default: begin
                n_result = quo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.result = r_result;
endmodule

FILE: hdl/q15_saturating_alu.sv
// channel  dir  modport  payload
// i_in     in   sink     opcode[1:0], operand_a[15:0] signed, operand_b[15:0] signed
// o_out    out  source   result[15:0] signed
//
// one operation per cycle while o_out is not stalled; from input transfer to result each operation
// passes one front stage, fifteen one-bit division cells and one output register
// every stage has its own valid bit, so bubbles close up under output stalls
// reset (i_rst_n, synchronous, active low) clears only the valid bits
module q15_saturating_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    q15alu_in_if.sink     i_in,
    q15alu_out_if.source  o_out
);
    import q15alu_pkg::*;

    // stage k valid and work word, stage 0 is the front register
    logic  stg_valid [NUM_CELLS+1];
    t_work stg_work  [NUM_CELLS+1];
    // entry k is the advance enable of stage k+1, last one is the output register
    logic  stg_adv   [NUM_CELLS+1];

    // operand decode, add, abs, multiply and divide setup
    q15alu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (stg_adv[0]),
        .o_valid (stg_valid[0]),
        .o_work  (stg_work[0])
    );

    // row of division cells, one quotient bit each, msb first
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        q15alu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_work  (stg_work[k]),
            .i_adv   (stg_adv[k+1]),
            .o_adv   (stg_adv[k]),
            .o_valid (stg_valid[k+1]),
            .o_work  (stg_work[k+1])
        );
    end

    // product shift and clamp, quotient sign, result register
    q15alu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[NUM_CELLS]),
        .i_work  (stg_work[NUM_CELLS]),
        .o_adv   (stg_adv[NUM_CELLS]),
        .o_out   (o_out)
    );
endmodule

FILE: sim/q15alu_checker.sv
module q15alu_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    q15alu_in_if  i_req,
    q15alu_out_if i_rsp,
    output int    o_fail_count,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import q15alu_pkg::*;

    typedef struct {
        t_opcode            op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] result;
    } t_alu_expect;

    t_alu_expect expected_q[$];

    function automatic logic signed [15:0] clamp_q15(input longint v);
        logic signed [15:0] r;
        if (v > 32767) begin
            r = 16'sh7fff;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] q15_alu_result(
        input t_opcode op,
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        longint             sa;
        longint             sb;
        longint             mag_a;
        longint             mag_b;
        logic signed [15:0] r;
        sa = longint'(a);
        sb = longint'(b);
        mag_a = (sa < 0) ? -sa : sa;
        mag_b = (sb < 0) ? -sb : sb;
        case (op)
            OP_ADD: r = clamp_q15(sa + sb);
            // arithmetic shift floors toward minus infinity
            OP_MUL: r = clamp_q15((sa * sb) >>> 15);
            OP_DIV: begin
                if (mag_a >= mag_b) begin
                    r = (a[15] != b[15]) ? 16'sh8000 : 16'sh7fff;
                end else begin
                    r = clamp_q15((sa * 32768) / sb);
                end
            end
            default: r = clamp_q15(mag_a);
        endcase
        return r;
    endfunction

    // counters are two-state and start at zero
    always @(posedge i_clk) begin
        t_alu_expect exp_item;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                exp_item.op     = i_req.opcode;
                exp_item.a      = i_req.operand_a;
                exp_item.b      = i_req.operand_b;
                exp_item.result = q15_alu_result(i_req.opcode, i_req.operand_a,
                                                 i_req.operand_b);
                expected_q.push_back(exp_item);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result %0d with no transfer outstanding", $time,
                             i_rsp.result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (i_rsp.result !== exp_item.result) begin
                        $display("%0t: %s a=%0d b=%0d expected %0d actual %0d", $time,
                                 exp_item.op.name(), exp_item.a, exp_item.b,
                                 exp_item.result, i_rsp.result);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_outstanding = expected_q.size();
        end
    end

endmodule

FILE: sim/tb_q15_saturating_alu.sv
module tb_q15_saturating_alu;
    timeunit 1ns;
    timeprecision 1ps;

    import q15alu_pkg::*;

    localparam int RANDOM_OPS = 1925;
    localparam int DRAIN_CYCLES = 40;   // a bit over twice the pipeline depth

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;

    q15alu_in_if  alu_in();
    q15alu_out_if alu_out();

    q15_saturating_alu u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (alu_in),
        .o_out   (alu_out)
    );

    // watches both channels, predicts every result and compares in order
    q15alu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (alu_in),
        .i_rsp         (alu_out),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // operand mix: full scale, near zero, and plain random words
    function automatic logic signed [15:0] pick_operand();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = Q15_MAX;
            1: v = Q15_MIN;
            2: v = 16'sh0000;
            3: begin
                v = 16'($urandom_range(0, 16));
                v = v - 16'sd8;
            end
            4: v = $urandom_range(0, 1) ? 16'sh7ffe : 16'sh8001;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // one transfer, called on a falling edge; returns on the falling edge after it
    task automatic send_op(input t_opcode op, input logic signed [15:0] a,
                           input logic signed [15:0] b);
        alu_in.valid     <= 1'b1;
        alu_in.opcode    <= op;
        alu_in.operand_a <= a;
        alu_in.operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!alu_in.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_op();
        t_opcode            op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        op = t_opcode'($urandom_range(0, 3));
        a  = pick_operand();
        b  = pick_operand();
        // steer some divides into the in-range quotient region
        if (op == OP_DIV && $urandom_range(0, 2) == 0) begin
            a = b >>> $urandom_range(1, 15);
            if ($urandom_range(0, 1)) begin
                a = -a;
            end
            if ($urandom_range(0, 7) == 0) begin
                a = a + 16'sd1;
            end
        end
        send_op(op, a, b);
    endtask

    // receiver: moves through randomly chosen stall patterns, each held for a random span
    initial begin
        int mode;
        int span;
        alu_out.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
            for (int i = 0; i < span; i++) begin
                @(negedge i_clk);
                case (mode)
                    0: alu_out.ready <= 1'b1;
                    1: alu_out.ready <= 1'($urandom_range(0, 1));
                    2: alu_out.ready <= (i % 3 == 0);
                    default: alu_out.ready <= ((i % 25) >= 20);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int sent;
        int burst;
        int gap;
        alu_in.valid     = 1'b0;
        alu_in.opcode    = OP_ADD;
        alu_in.operand_a = 16'sh0000;
        alu_in.operand_b = 16'sh0000;
        i_rst_n          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners, back to back
        send_op(OP_ADD, Q15_MAX, Q15_MAX);           // positive overflow
        send_op(OP_ADD, Q15_MIN, Q15_MIN);           // negative overflow
        send_op(OP_ADD, Q15_MAX, Q15_MIN);
        send_op(OP_ADD, -16'sd5, 16'sd3);
        send_op(OP_MUL, Q15_MIN, Q15_MIN);           // -1 * -1 saturates
        send_op(OP_MUL, Q15_MAX, Q15_MAX);
        send_op(OP_MUL, Q15_MIN, Q15_MAX);
        send_op(OP_MUL, -16'sd1, 16'sd1);            // floor of a tiny negative
        send_op(OP_MUL, 16'sd1, 16'sd1);
        send_op(OP_DIV, 16'sd1234, 16'sh0000);       // divide by zero, positive
        send_op(OP_DIV, -16'sd1234, 16'sh0000);      // divide by zero, negative
        send_op(OP_DIV, 16'sh0000, 16'sh0000);
        send_op(OP_DIV, 16'sd500, 16'sd500);         // magnitude equal
        send_op(OP_DIV, 16'sd500, -16'sd500);
        send_op(OP_DIV, Q15_MIN, Q15_MIN);
        send_op(OP_DIV, Q15_MIN, Q15_MAX);
        send_op(OP_DIV, 16'sd16384, Q15_MIN);        // in range, mixed signs
        send_op(OP_DIV, -16'sd1, Q15_MAX);           // truncation toward zero
        send_op(OP_DIV, Q15_MAX - 16'sd1, Q15_MAX);
        send_op(OP_ABS, Q15_MIN, 16'sh1234);         // most negative saturates
        send_op(OP_ABS, Q15_MAX, Q15_MIN);
        send_op(OP_ABS, 16'sh0000, Q15_MAX);
        send_op(OP_ABS, -16'sd1, 16'sh0000);

        // random bursts with idle gaps; some long unbroken runs
        sent = 0;
        while (sent < RANDOM_OPS) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_OPS; i++) begin
                send_random_op();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                // junk payload while valid is low
                alu_in.valid     <= 1'b0;
                alu_in.opcode    <= t_opcode'($urandom_range(0, 3));
                alu_in.operand_a <= 16'($urandom);
                alu_in.operand_b <= 16'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        alu_in.valid <= 1'b0;

        // drain, then wait out DRAIN_CYCLES to catch stray results
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
